// ===== hdl/hdmbc_pkg.sv =====
package hdmbc_pkg;

   // cache geometry
   localparam int ENTRIES      = 256;
   localparam int IDX_W        = $clog2(ENTRIES);
   localparam int BLOCK_PIXELS = 64;
   localparam int SLOT_W       = 6;
   localparam int CNT_W        = SLOT_W + 1;
   localparam int WORD_W       = 32;
   localparam int KEY_W        = 3 * WORD_W;
   localparam int TOTAL_W      = 64;
   localparam int PIX_DEPTH    = ENTRIES * BLOCK_PIXELS;
   localparam int PIX_AW       = IDX_W + SLOT_W;

   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(BLOCK_PIXELS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BLOCK_PIXELS - 1);

   // hash multipliers
   localparam logic [WORD_W-1:0] HASH_MUL_GLYPH = 32'd1103515243;
   localparam logic [WORD_W-1:0] HASH_MUL_FORE  = 32'd101511;
   localparam logic [WORD_W-1:0] HASH_MUL_BACK  = 32'd3571;

   // h mod ENTRIES by reciprocal: q = (h * floor(2^32/N)) >> 32 is low by at most one
   localparam logic [WORD_W-1:0] ENTRIES_W = WORD_W'(ENTRIES);
   localparam logic [63:0]       MOD_RECIP = 64'h1_0000_0000 / 64'(ENTRIES);

   typedef enum logic [1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_LOAD   = 2'd1,
      MODE_COMMIT = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_DECIDE,
      ST_COMMIT,
      ST_STREAM,
      ST_COPY
   } state_type;

   // memory port requests from the controller to the store
   typedef struct packed {
      logic                 key_rd_en;
      logic                 key_wr_en;
      logic [IDX_W-1:0]     key_idx;
      logic [KEY_W-1:0]     key_wdata;
      logic                 pix_rd_en;
      logic                 pix_wr_en;
      logic [PIX_AW-1:0]    pix_addr;
      logic [WORD_W-1:0]    pix_wdata;
      logic                 stg_rd_en;
      logic                 stg_wr_en;
      logic [SLOT_W-1:0]    stg_addr;
      logic [WORD_W-1:0]    stg_wdata;
   } store_req_type;

endpackage

// ===== hdl/hdmbc_hash.sv =====
module hdmbc_hash (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [hdmbc_pkg::WORD_W-1:0] glyph_code,
   input  logic [hdmbc_pkg::WORD_W-1:0] fore_color,
   input  logic [hdmbc_pkg::WORD_W-1:0] back_color,
   output logic                         out_valid,
   output logic [hdmbc_pkg::IDX_W-1:0]  index
);
   import hdmbc_pkg::*;

   localparam int STAGES = 5;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic [WORD_W-1:0] prod_g_ff, prod_g_in;
   logic [WORD_W-1:0] prod_f_ff, prod_f_in;
   logic [WORD_W-1:0] prod_b_ff, prod_b_in;
   logic [WORD_W-1:0] hash_ff, hash_in;
   logic [WORD_W-1:0] hash3_ff, hash3_in;
   logic [WORD_W-1:0] quot_ff, quot_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   logic [63:0]       recip_prod;
   logic [WORD_W-1:0] rem_fix;

   always_comb begin
      vld_in     = {vld_ff[STAGES-2:0], in_valid};
      // stage 1: three constant products, mod 2^32
      prod_g_in  = glyph_code * HASH_MUL_GLYPH;
      prod_f_in  = fore_color * HASH_MUL_FORE;
      prod_b_in  = back_color * HASH_MUL_BACK;
      // stage 2: fold
      hash_in    = prod_g_ff ^ prod_f_ff ^ prod_b_ff;
      // stage 3: quotient estimate
      recip_prod = 64'(hash_ff) * MOD_RECIP;
      quot_in    = recip_prod[63:32];
      hash3_in   = hash_ff;
      // stage 4: remainder, below 2N
      rem_in     = hash3_ff - quot_ff * ENTRIES_W;
      // stage 5: one correction
      rem_fix    = (rem_ff >= ENTRIES_W) ? rem_ff - ENTRIES_W : rem_ff;
      index_in   = rem_fix[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_g_ff <= prod_g_in;
      prod_f_ff <= prod_f_in;
      prod_b_ff <= prod_b_in;
      hash_ff   <= hash_in;
      hash3_ff  <= hash3_in;
      quot_ff   <= quot_in;
      rem_ff    <= rem_in;
      index_ff  <= index_in;
   end

   assign out_valid = vld_ff[STAGES-1];
   assign index     = index_ff;

endmodule

// ===== hdl/hdmbc_store.sv =====
module hdmbc_store (
   input  logic                          clock,
   input  hdmbc_pkg::store_req_type      req,
   output logic [hdmbc_pkg::KEY_W-1:0]   key_rdata,
   output logic [hdmbc_pkg::WORD_W-1:0]  pix_rdata,
   output logic [hdmbc_pkg::WORD_W-1:0]  stg_rdata
);
   import hdmbc_pkg::*;

   logic [KEY_W-1:0]  key_mem [ENTRIES];
   logic [WORD_W-1:0] pix_mem [PIX_DEPTH];
   logic [WORD_W-1:0] stg_mem [BLOCK_PIXELS];

   logic [KEY_W-1:0]  key_rdata_ff;
   logic [WORD_W-1:0] pix_rdata_ff;
   logic [WORD_W-1:0] stg_rdata_ff;

   // tags
   always_ff @(posedge clock) begin
      if (req.key_wr_en) begin
         key_mem[req.key_idx] <= req.key_wdata;
      end
      if (req.key_rd_en) begin
         key_rdata_ff <= key_mem[req.key_idx];
      end
   end

   // pixel blocks, entry index in the upper address bits
   always_ff @(posedge clock) begin
      if (req.pix_wr_en) begin
         pix_mem[req.pix_addr] <= req.pix_wdata;
      end
      if (req.pix_rd_en) begin
         pix_rdata_ff <= pix_mem[req.pix_addr];
      end
   end

   // staging block
   always_ff @(posedge clock) begin
      if (req.stg_wr_en) begin
         stg_mem[req.stg_addr] <= req.stg_wdata;
      end
      if (req.stg_rd_en) begin
         stg_rdata_ff <= stg_mem[req.stg_addr];
      end
   end

   assign key_rdata = key_rdata_ff;
   assign pix_rdata = pix_rdata_ff;
   assign stg_rdata = stg_rdata_ff;

endmodule

// ===== hdl/hashed_direct_mapped_block_cache.sv =====
// Direct-mapped cache of 8x8 RGBA pixel blocks keyed by {glyph code, foreground, background}.
// The entry index is the XOR of the three key words times fixed odd constants (mod 2^32), taken
// mod the entry count; it comes out of a five-stage hash pipeline. One transaction is taken at
// a time. A staged-pixel load or a clear is done without leaving the idle state. A lookup runs
// the hash and then the tag read; a miss then gives its one result and the block goes back to
// idle for the next transaction. A hit streams the 64 stored pixels at one per cycle while the
// consumer keeps up, through the single read port of the pixel memory. A commit runs the
// hash, the tag write, then a copy of the staging block into the entry through the staging
// memory's read port, one pixel per cycle. The valid bits are flops cleared at once by reset
// or by a clear, so there is no clearing pass after reset. The three totals ride on every
// result and are the values after the lookup that produced it has been counted; a new
// transaction may be taken while the last result still waits on rsp_stall.
module hashed_direct_mapped_block_cache (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_mode,
   input  logic [hdmbc_pkg::WORD_W-1:0]  req_glyph_code,
   input  logic [hdmbc_pkg::WORD_W-1:0]  req_fore_color,
   input  logic [hdmbc_pkg::WORD_W-1:0]  req_back_color,
   input  logic [hdmbc_pkg::SLOT_W-1:0]  req_pixel_slot,
   input  logic [hdmbc_pkg::WORD_W-1:0]  req_pixel_word,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [hdmbc_pkg::SLOT_W-1:0]  rsp_out_slot,
   output logic [hdmbc_pkg::WORD_W-1:0]  rsp_out_pixel,
   output logic                          rsp_run_end,
   output logic [hdmbc_pkg::TOTAL_W-1:0] rsp_hit_total,
   output logic [hdmbc_pkg::TOTAL_W-1:0] rsp_miss_total,
   output logic [hdmbc_pkg::TOTAL_W-1:0] rsp_evict_total
);
   import hdmbc_pkg::*;

   // control state
   state_type           state_ff, state_in;
   mode_type            mode_ff, mode_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;        // reads issued in stream / copy
   logic                pend_ff, pend_in;      // memory read data waiting to be used
   logic [SLOT_W-1:0]   pend_slot_ff, pend_slot_in;
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [TOTAL_W-1:0]  hit_ff, hit_in;
   logic [TOTAL_W-1:0]  miss_ff, miss_in;
   logic [TOTAL_W-1:0]  evict_ff, evict_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [WORD_W-1:0]   rsp_pixel_ff, rsp_pixel_in;
   logic                rsp_run_end_ff, rsp_run_end_in;
   logic [TOTAL_W-1:0]  rsp_hit_ff, rsp_hit_in;
   logic [TOTAL_W-1:0]  rsp_miss_ff, rsp_miss_in;
   logic [TOTAL_W-1:0]  rsp_evict_ff, rsp_evict_in;

   logic                out_free;
   logic                out_load;
   logic                issue;
   logic                hit;
   logic                hash_start;
   logic                hash_valid;
   logic [IDX_W-1:0]    hash_index;
   store_req_type       store_req;
   logic [KEY_W-1:0]    key_rdata;
   logic [WORD_W-1:0]   pix_rdata;
   logic [WORD_W-1:0]   stg_rdata;

   hdmbc_hash u_hash (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (hash_start),
      .glyph_code (req_glyph_code),
      .fore_color (req_fore_color),
      .back_color (req_back_color),
      .out_valid  (hash_valid),
      .index      (hash_index)
   );

   hdmbc_store u_store (
      .clock     (clock),
      .req       (store_req),
      .key_rdata (key_rdata),
      .pix_rdata (pix_rdata),
      .stg_rdata (stg_rdata)
   );

   // the response register can take a result this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // tag compare against the key captured with the transaction
   assign hit      = valid_ff[idx_ff] && (key_rdata == key_ff);

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      key_in         = key_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      pend_in        = pend_ff;
      pend_slot_in   = pend_slot_ff;
      valid_in       = valid_ff;
      hit_in         = hit_ff;
      miss_in        = miss_ff;
      evict_in       = evict_ff;

      req_stall      = (state_ff != ST_IDLE);
      hash_start     = 1'b0;
      out_load       = 1'b0;
      issue          = 1'b0;

      rsp_found_in   = 1'b1;
      rsp_slot_in    = pend_slot_ff;
      rsp_pixel_in   = pix_rdata;
      rsp_run_end_in = (pend_slot_ff == LAST_SLOT);
      rsp_hit_in     = hit_ff;
      rsp_miss_in    = miss_ff;
      rsp_evict_in   = evict_ff;

      store_req           = '0;
      store_req.key_idx   = idx_ff;
      store_req.key_wdata = key_ff;
      store_req.pix_addr  = {idx_ff, cnt_ff[SLOT_W-1:0]};
      store_req.pix_wdata = stg_rdata;
      store_req.stg_addr  = req_pixel_slot;
      store_req.stg_wdata = req_pixel_word;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = mode_type'(req_mode);
               key_in  = {req_glyph_code, req_fore_color, req_back_color};
               case (mode_type'(req_mode))
                  MODE_LOAD: begin
                     store_req.stg_wr_en = 1'b1;
                  end
                  MODE_CLEAR: begin
                     valid_in = '0;
                     hit_in   = '0;
                     miss_in  = '0;
                     evict_in = '0;
                  end
                  MODE_LOOKUP, MODE_COMMIT: begin
                     hash_start = 1'b1;
                     state_in   = ST_HASH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_HASH: begin
            if (hash_valid) begin
               idx_in = hash_index;
               if (mode_ff == MODE_LOOKUP) begin
                  store_req.key_rd_en = 1'b1;
                  store_req.key_idx   = hash_index;
                  state_in            = ST_DECIDE;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end

         ST_DECIDE: begin
            if (out_free) begin
               cnt_in  = '0;
               pend_in = 1'b0;
               if (hit) begin
                  hit_in   = hit_ff + 64'd1;
                  state_in = ST_STREAM;
               end else begin
                  // single miss result
                  miss_in        = miss_ff + 64'd1;
                  out_load       = 1'b1;
                  rsp_found_in   = 1'b0;
                  rsp_slot_in    = '0;
                  rsp_pixel_in   = '0;
                  rsp_run_end_in = 1'b1;
                  rsp_miss_in    = miss_ff + 64'd1;
                  state_in       = ST_IDLE;
               end
            end
         end

         ST_COMMIT: begin
            store_req.key_wr_en = 1'b1;
            if (valid_ff[idx_ff]) begin
               evict_in = evict_ff + 64'd1;
            end
            valid_in[idx_ff] = 1'b1;
            cnt_in           = '0;
            pend_in          = 1'b0;
            state_in         = ST_COPY;
         end

         ST_STREAM: begin
            // one read in flight; next read goes out as the previous pixel leaves
            out_load            = pend_ff && out_free;
            issue               = (cnt_ff != CNT_FULL) && (!pend_ff || out_load);
            store_req.pix_rd_en = issue;
            if (issue) begin
               cnt_in       = cnt_ff + 1'b1;
               pend_slot_in = cnt_ff[SLOT_W-1:0];
               pend_in      = 1'b1;
            end else if (out_load) begin
               pend_in = 1'b0;
            end
            if (out_load && (cnt_ff == CNT_FULL)) begin
               state_in = ST_IDLE;
            end
         end

         ST_COPY: begin
            // staging read at cnt, entry write in the following cycle
            issue               = (cnt_ff != CNT_FULL);
            store_req.stg_rd_en = issue;
            store_req.stg_addr  = cnt_ff[SLOT_W-1:0];
            if (pend_ff) begin
               store_req.pix_wr_en = 1'b1;
               store_req.pix_addr  = {idx_ff, pend_slot_ff};
            end
            pend_in = issue;
            if (issue) begin
               cnt_in       = cnt_ff + 1'b1;
               pend_slot_in = cnt_ff[SLOT_W-1:0];
            end
            if (pend_ff && (cnt_ff == CNT_FULL)) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         evict_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         evict_ff     <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      pend_slot_ff <= pend_slot_in;
      if (out_load) begin
         rsp_found_ff   <= rsp_found_in;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_pixel_ff   <= rsp_pixel_in;
         rsp_run_end_ff <= rsp_run_end_in;
         rsp_hit_ff     <= rsp_hit_in;
         rsp_miss_ff    <= rsp_miss_in;
         rsp_evict_ff   <= rsp_evict_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_out_slot    = rsp_slot_ff;
   assign rsp_out_pixel   = rsp_pixel_ff;
   assign rsp_run_end     = rsp_run_end_ff;
   assign rsp_hit_total   = rsp_hit_ff;
   assign rsp_miss_total  = rsp_miss_ff;
   assign rsp_evict_total = rsp_evict_ff;

endmodule

// ===== hdl/hdmbc_check.sv =====
module hdmbc_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [1:0]                    req_mode,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_found,
   input logic [hdmbc_pkg::SLOT_W-1:0]  rsp_out_slot,
   input logic [hdmbc_pkg::WORD_W-1:0]  rsp_out_pixel,
   input logic                          rsp_run_end
);
   import hdmbc_pkg::*;

   // a miss is a single transaction
   a_miss_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> rsp_run_end)
      else $error("miss result without run end");

   // a hit run ends exactly on the last slot
   a_run_end_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_run_end == (rsp_out_slot == LAST_SLOT)))
      else $error("hit run end on wrong slot");

   // hit pixels follow back to back in slot order
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_found && !rsp_run_end) |=>
         (rsp_valid && rsp_found &&
          rsp_out_slot == SLOT_W'($past(rsp_out_slot) + 1'b1)))
      else $error("hit pixel out of order or gap in run");

   // a lookup holds off further requests
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_mode == MODE_LOOKUP) |=> req_stall)
      else $error("request taken during lookup");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_pixel)))
      else $error("stalled response changed");

endmodule

bind hashed_direct_mapped_block_cache hdmbc_check u_hdmbc_check (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_mode      (req_mode),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_found     (rsp_found),
   .rsp_out_slot  (rsp_out_slot),
   .rsp_out_pixel (rsp_out_pixel),
   .rsp_run_end   (rsp_run_end)
);
